### hw/rtl/crse_pkg.sv
// shared types and constants of the catmull-rom spline evaluator
package crse_pkg;

  localparam int unsigned MAX_POINTS  = 16;
  localparam int unsigned T_FRAC_BITS = 16;
  localparam int unsigned ADDR_W      = $clog2(MAX_POINTS);
  localparam int unsigned T_POS_W     = T_FRAC_BITS + 1;
  localparam int unsigned NUM_W       = 5;
  localparam int unsigned SEG_W       = 4;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned NUM_MIN     = 4;
  localparam int unsigned NUM_TAPS    = 4;
  // accumulator holds the horner partial sums, product adds the u operand
  localparam int unsigned ACC_W       = 38;
  localparam int unsigned PROD_W      = ACC_W + T_POS_W + 1;
  localparam int unsigned SCALED_W    = T_POS_W + SEG_W;
  // register stages inside one axis lane
  localparam int unsigned LANE_DEPTH  = 7;

  localparam logic [T_POS_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } crse_action_e;

  typedef struct packed {
    crse_action_e               action;
    logic [IDX_W-1:0]           point_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic [T_POS_W-1:0]         t_pos;
  } crse_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
    logic [SEG_W-1:0]           segment;
  } crse_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } crse_point_t;

  typedef struct packed {
    logic              valid;
    logic [SEG_W-1:0]  seg;
  } crse_tag_t;

endpackage

### hw/rtl/crse_point_store.sv
// control point memory, one copy per read tap, registered reads
module crse_point_store import crse_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  wr_addr_i,
  input  crse_point_t        wr_data_i,
  input  logic [ADDR_W-1:0]  rd_addr_i [NUM_TAPS],
  output crse_point_t        rd_data_o [NUM_TAPS]
);

  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_bank
    crse_point_t mem_q [MAX_POINTS];
    crse_point_t rd_q;

    // every bank takes the same write so the copies stay identical
    always_ff @(posedge clk_i) begin
      if (we_i) begin
        mem_q[wr_addr_i] <= wr_data_i;
      end
      rd_q <= mem_q[rd_addr_i[k]];
    end

    assign rd_data_o[k] = rd_q;
  end

endmodule

### hw/rtl/crse_axis_lane.sv
// one axis of the spline: coefficients and a three step horner pipeline
module crse_axis_lane import crse_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [COORD_W-1:0] p_i [NUM_TAPS],
  input  logic [T_POS_W-1:0]        u_i,
  output logic signed [ACC_W-1:0]   acc_o
);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (T_FRAC_BITS - 1);

  // round to nearest, ties up, then add the next coefficient
  function automatic logic signed [ACC_W-1:0] rnd_add(input logic signed [PROD_W-1:0] prod,
                                                      input logic signed [ACC_W-1:0] e);
    logic signed [PROD_W-1:0] r;
    r = prod + RND_HALF;
    return $signed(ACC_W'(r >>> T_FRAC_BITS)) + e;
  endfunction

  logic signed [ACC_W-1:0]  q0, q1, q2, q3;
  logic signed [ACC_W-1:0]  e3_d, e2_d, e1_d, e0_d;

  logic signed [ACC_W-1:0]  e3_q, e2_q, e1_q, e0_q;
  logic [T_POS_W-1:0]       u_c_q;

  logic signed [PROD_W-1:0] prod1_q;
  logic signed [ACC_W-1:0]  m1_e2_q, m1_e1_q, m1_e0_q;
  logic [T_POS_W-1:0]       u_m1_q;

  logic signed [ACC_W-1:0]  acc1_q, a1_e1_q, a1_e0_q;
  logic [T_POS_W-1:0]       u_a1_q;

  logic signed [PROD_W-1:0] prod2_q;
  logic signed [ACC_W-1:0]  m2_e1_q, m2_e0_q;
  logic [T_POS_W-1:0]       u_m2_q;

  logic signed [ACC_W-1:0]  acc2_q, a2_e0_q;
  logic [T_POS_W-1:0]       u_a2_q;

  logic signed [PROD_W-1:0] prod3_q;
  logic signed [ACC_W-1:0]  m3_e0_q;

  logic signed [ACC_W-1:0]  acc3_q;

  assign q0 = ACC_W'(p_i[0]);
  assign q1 = ACC_W'(p_i[1]);
  assign q2 = ACC_W'(p_i[2]);
  assign q3 = ACC_W'(p_i[3]);

  always_comb begin
    e3_d = q3 - q0 + (q1 <<< 1) + q1 - (q2 <<< 1) - q2;
    e2_d = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
    e1_d = q2 - q0;
    e0_d = q1 <<< 1;
  end

  always_ff @(posedge clk_i) begin
    e3_q    <= e3_d;
    e2_q    <= e2_d;
    e1_q    <= e1_d;
    e0_q    <= e0_d;
    u_c_q   <= u_i;

    prod1_q <= e3_q * $signed({1'b0, u_c_q});
    m1_e2_q <= e2_q;
    m1_e1_q <= e1_q;
    m1_e0_q <= e0_q;
    u_m1_q  <= u_c_q;

    acc1_q  <= rnd_add(prod1_q, m1_e2_q);
    a1_e1_q <= m1_e1_q;
    a1_e0_q <= m1_e0_q;
    u_a1_q  <= u_m1_q;

    prod2_q <= acc1_q * $signed({1'b0, u_a1_q});
    m2_e1_q <= a1_e1_q;
    m2_e0_q <= a1_e0_q;
    u_m2_q  <= u_a1_q;

    acc2_q  <= rnd_add(prod2_q, m2_e1_q);
    a2_e0_q <= m2_e0_q;
    u_a2_q  <= u_m2_q;

    prod3_q <= acc2_q * $signed({1'b0, u_a2_q});
    m3_e0_q <= a2_e0_q;

    acc3_q  <= rnd_add(prod3_q, m3_e0_q);
  end

  assign acc_o = acc3_q;

endmodule

### hw/rtl/crse_merge.sv
// halves and saturates the three lane sums and registers the result
module crse_merge import crse_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  crse_tag_t               tag_i,
  input  logic signed [ACC_W-1:0] acc_x_i,
  input  logic signed [ACC_W-1:0] acc_y_i,
  input  logic signed [ACC_W-1:0] acc_z_i,
  output logic                    done_o,
  output crse_out_t               result_o
);

  function automatic logic signed [COORD_W-1:0] half_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] h;
    h = (a + ACC_W'(1)) >>> 1;
    // fits when all bits above the 32-bit sign agree with it
    if (&h[ACC_W-1:COORD_W-1] || ~|h[ACC_W-1:COORD_W-1]) begin
      return h[COORD_W-1:0];
    end else if (h[ACC_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  logic      done_q;
  crse_out_t result_q;
  crse_out_t result_d;

  always_comb begin
    result_d.pos_x   = half_sat(acc_x_i);
    result_d.pos_y   = half_sat(acc_y_i);
    result_d.pos_z   = half_sat(acc_z_i);
    result_d.segment = tag_i.seg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### hw/rtl/catmull_rom_spline_eval.sv
// top level of the catmull-rom spline evaluator
//
//   channel   ports                        handshake
//   ------    -----------------------      ------------------------------
//   input     start_i, busy_o, item_i      taken when start_i and !busy_o
//   result    done_o, result_o             one-cycle strobe, no back-pressure
//   config    cfg_we_i, cfg_wdata_i        written when cfg_we_i is high
//
// one item is taken every clock; busy_o stays low
// an evaluate item gives its result through the registers of its path:
// one for the point memory read, seven in each axis lane, one in the merge
// a point write is visible to an evaluate item taken on the next edge
// reset clears the valid line and sets num_points to 4, points are not cleared
module catmull_rom_spline_eval import crse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  crse_in_t          item_i,
  output logic              done_o,
  output crse_out_t         result_o,
  input  logic              cfg_we_i,
  input  logic [NUM_W-1:0]  cfg_wdata_i
);

  logic [NUM_W-1:0]    num_points_q;
  logic [NUM_W-1:0]    n_eff;
  logic [SEG_W-1:0]    segs;
  logic [T_POS_W-1:0]  t_clamp;
  logic [SCALED_W-1:0] scaled;
  logic [NUM_W-1:0]    seg_raw;
  logic [SEG_W-1:0]    seg_d;
  logic [T_POS_W-1:0]  u_d;
  logic [NUM_W-1:0]    i3_wide;
  logic [ADDR_W-1:0]   rd_addr [NUM_TAPS];

  logic                accept;
  logic                eval_acc;
  logic                point_we;

  logic                v1_q;
  logic [SEG_W-1:0]    seg1_q;
  logic [T_POS_W-1:0]  u1_q;
  crse_tag_t           tag_q [LANE_DEPTH];

  crse_point_t         wr_point;
  crse_point_t         rd_point [NUM_TAPS];
  logic signed [COORD_W-1:0] px [NUM_TAPS];
  logic signed [COORD_W-1:0] py [NUM_TAPS];
  logic signed [COORD_W-1:0] pz [NUM_TAPS];
  logic signed [ACC_W-1:0]   acc_x, acc_y, acc_z;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign eval_acc = accept && (item_i.action == ACT_EVAL);
  assign point_we = accept && (item_i.action == ACT_WRITE) &&
                    ((IDX_W + 1)'(item_i.point_index) < (IDX_W + 1)'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= NUM_W'(NUM_MIN);
    end else if (cfg_we_i) begin
      num_points_q <= cfg_wdata_i;
    end
  end

  // segment and local parameter from the global t
  always_comb begin
    if (num_points_q < NUM_W'(NUM_MIN)) begin
      n_eff = NUM_W'(NUM_MIN);
    end else if (num_points_q > NUM_W'(MAX_POINTS)) begin
      n_eff = NUM_W'(MAX_POINTS);
    end else begin
      n_eff = num_points_q;
    end
    segs    = SEG_W'(n_eff - NUM_W'(1));
    t_clamp = (item_i.t_pos > T_ONE) ? T_ONE : item_i.t_pos;
    scaled  = SCALED_W'(t_clamp) * SCALED_W'(segs);
    seg_raw = NUM_W'(scaled[SCALED_W-1:T_FRAC_BITS]);
    if (seg_raw >= NUM_W'(segs)) begin
      // end of curve: last segment at u of one
      seg_d = segs - SEG_W'(1);
      u_d   = T_ONE;
    end else begin
      seg_d = seg_raw[SEG_W-1:0];
      u_d   = {1'b0, scaled[T_FRAC_BITS-1:0]};
    end
    i3_wide    = NUM_W'(seg_d) + NUM_W'(2);
    rd_addr[1] = ADDR_W'(seg_d);
    rd_addr[2] = ADDR_W'(seg_d + SEG_W'(1));
    rd_addr[0] = (seg_d == '0) ? ADDR_W'(seg_d) : ADDR_W'(seg_d - SEG_W'(1));
    rd_addr[3] = (i3_wide >= n_eff) ? rd_addr[2] : ADDR_W'(i3_wide);
  end

  assign wr_point.x = item_i.coord_x;
  assign wr_point.y = item_i.coord_y;
  assign wr_point.z = item_i.coord_z;

  crse_point_store u_store (
    .clk_i     (clk_i),
    .we_i      (point_we),
    .wr_addr_i (ADDR_W'(item_i.point_index)),
    .wr_data_i (wr_point),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_point)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      for (int i = 0; i < LANE_DEPTH; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      v1_q     <= eval_acc;
      tag_q[0] <= '{valid: v1_q, seg: seg1_q};
      for (int i = 1; i < LANE_DEPTH; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seg1_q <= seg_d;
    u1_q   <= u_d;
  end

  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
    assign px[k] = rd_point[k].x;
    assign py[k] = rd_point[k].y;
    assign pz[k] = rd_point[k].z;
  end

  crse_axis_lane u_lane_x (.clk_i(clk_i), .p_i(px), .u_i(u1_q), .acc_o(acc_x));
  crse_axis_lane u_lane_y (.clk_i(clk_i), .p_i(py), .u_i(u1_q), .acc_o(acc_y));
  crse_axis_lane u_lane_z (.clk_i(clk_i), .p_i(pz), .u_i(u1_q), .acc_o(acc_z));

  crse_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag_q[LANE_DEPTH-1]),
    .acc_x_i  (acc_x),
    .acc_y_i  (acc_y),
    .acc_z_i  (acc_z),
    .done_o   (done_o),
    .result_o (result_o)
  );

`ifndef NO_ASSERTIONS
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(eval_acc, LANE_DEPTH + 2))
    else $error("result strobe without an evaluate item");

  a_item_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_acc |-> ##(LANE_DEPTH + 2) done_o)
    else $error("evaluate item produced no result");

  a_write_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.action == ACT_WRITE) |-> ##(LANE_DEPTH + 2) !done_o)
    else $error("point write produced a result");

  a_segment_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (NUM_W'(result_o.segment) <= n_eff - NUM_W'(2)))
    else $error("segment beyond last segment");
`endif

endmodule

### tb/sv/catmull_rom_spline_eval_tb.sv
// self-checking testbench of the catmull-rom spline evaluator
`timescale 1ns / 100ps

module catmull_rom_spline_eval_tb;
  import crse_pkg::*;

  localparam int unsigned LATENCY     = 9;
  localparam int unsigned DRAIN       = LATENCY + 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS = 212;

  // tracks control points and num_points, predicts each evaluation
  class spline_checker;
    crse_point_t      pts [MAX_POINTS];
    logic [NUM_W-1:0] num_points;
    crse_out_t        expected_pos [$];
    int unsigned      mismatches;
    int unsigned      evals;
    int unsigned      writes;

    function new();
      num_points = NUM_W'(NUM_MIN);
      mismatches = 0;
      evals      = 0;
      writes     = 0;
    endfunction

    function int unsigned active_points();
      if (num_points < NUM_MIN) return NUM_MIN;
      if (num_points > MAX_POINTS) return MAX_POINTS;
      return num_points;
    endfunction

    function logic signed [COORD_W-1:0] curve_axis(longint p0, longint p1, longint p2,
                                                   longint p3, longint u);
      longint e3, e2, e1, e0, acc, half;
      half = longint'(1) << (T_FRAC_BITS - 1);
      e3 = -p0 + 3 * p1 - 3 * p2 + p3;
      e2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      e1 = p2 - p0;
      e0 = 2 * p1;
      // horner with round to nearest, ties toward +inf
      acc = ((e3 * u + half) >>> T_FRAC_BITS) + e2;
      acc = ((acc * u + half) >>> T_FRAC_BITS) + e1;
      acc = ((acc * u + half) >>> T_FRAC_BITS) + e0;
      acc = (acc + 1) >>> 1;
      if (acc > 64'sh7fffffff) acc = 64'sh7fffffff;
      if (acc < -64'sh80000000) acc = -64'sh80000000;
      return acc[COORD_W-1:0];
    endfunction

    function void note_item(crse_in_t it);
      int unsigned n, segs, t, scaled, seg, u, i0, i1, i2, i3;
      crse_out_t   want;
      if (it.action == ACT_WRITE) begin
        pts[it.point_index] = '{x: it.coord_x, y: it.coord_y, z: it.coord_z};
        writes++;
        return;
      end
      n = active_points();
      segs = n - 1;
      t = it.t_pos;
      if (t > T_ONE) t = T_ONE;
      scaled = t * segs;
      seg = scaled >> T_FRAC_BITS;
      u = scaled & ((1 << T_FRAC_BITS) - 1);
      // end of curve clamps to the last segment at u of one
      if (seg >= segs) begin
        seg = segs - 1;
        u = T_ONE;
      end
      i1 = seg;
      i2 = seg + 1;
      i0 = (seg == 0) ? seg : seg - 1;
      i3 = (seg + 2 >= n) ? i2 : seg + 2;
      want.pos_x = curve_axis($signed(pts[i0].x), $signed(pts[i1].x),
                              $signed(pts[i2].x), $signed(pts[i3].x), u);
      want.pos_y = curve_axis($signed(pts[i0].y), $signed(pts[i1].y),
                              $signed(pts[i2].y), $signed(pts[i3].y), u);
      want.pos_z = curve_axis($signed(pts[i0].z), $signed(pts[i1].z),
                              $signed(pts[i2].z), $signed(pts[i3].z), u);
      want.segment = SEG_W'(seg);
      expected_pos.push_back(want);
      evals++;
    endfunction

    function void check_sample(crse_out_t got);
      crse_out_t want;
      if (expected_pos.size() == 0) begin
        $error("unexpected result: segment %0d pos_x %0d", got.segment, got.pos_x);
        mismatches++;
        return;
      end
      want = expected_pos.pop_front();
      if (got.pos_x !== want.pos_x) begin
        $error("pos_x mismatch: expected %0d, actual %0d", want.pos_x, got.pos_x);
        mismatches++;
      end
      if (got.pos_y !== want.pos_y) begin
        $error("pos_y mismatch: expected %0d, actual %0d", want.pos_y, got.pos_y);
        mismatches++;
      end
      if (got.pos_z !== want.pos_z) begin
        $error("pos_z mismatch: expected %0d, actual %0d", want.pos_z, got.pos_z);
        mismatches++;
      end
      if (got.segment !== want.segment) begin
        $error("segment mismatch: expected %0d, actual %0d", want.segment, got.segment);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  crse_in_t         item_i;
  logic             done_o;
  crse_out_t        result_o;
  logic             cfg_we_i;
  logic [NUM_W-1:0] cfg_wdata_i;

  spline_checker spline = new();
  int unsigned   cycle_count;
  int unsigned   settings_used;

  catmull_rom_spline_eval uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("catmull_rom_spline_eval regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) spline.num_points = cfg_wdata_i;
      if (start_i && !busy_o) spline.note_item(item_i);
      if (done_o) spline.check_sample(result_o);
    end
  end

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3, 4: return COORD_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [T_POS_W-1:0] pick_t(int unsigned segs);
    int unsigned k;
    k = $urandom_range(1, segs - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return T_ONE;
      2: return T_POS_W'($urandom_range(32'h10001, 32'h1ffff));
      // land on or next to a segment boundary
      3, 4: return T_POS_W'(((k << T_FRAC_BITS) / segs) + $urandom_range(0, 2));
      default: return T_POS_W'($urandom_range(0, 32'hffff));
    endcase
  endfunction

  task automatic drive_item(crse_in_t it, int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // hold off until every pending evaluation has come back, then let the pipe drain
  task automatic settle();
    start_i <= 1'b0;
    while (spline.expected_pos.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_num_points(logic [NUM_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    crse_in_t           it;
    logic [NUM_W-1:0]   phase_points [NUM_PHASES];
    logic [T_POS_W-1:0] edge_t [8];
    int unsigned        idle_pct;

    rst_ni        = 1'b0;
    start_i       = 1'b0;
    item_i        = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    cycle_count   = 0;
    settings_used = 1;
    phase_points  = '{5'd16, 5'd0, 5'd31, 5'd9, 5'd4, 5'd17, 5'd3,
                      NUM_W'($urandom_range(5, 15))};
    edge_t        = '{17'd0, 17'd1, 17'd21845, 17'd21846, 17'd32768,
                      17'd65535, 17'd65536, 17'h1ffff};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load every slot with extreme patterns before any evaluation reads one
    for (int i = 0; i < MAX_POINTS; i++) begin
      it = '0;
      it.action      = ACT_WRITE;
      it.point_index = IDX_W'(i);
      it.coord_x     = (i % 4 == 0) ? 32'sh7fffffff : (i % 4 == 1) ? 32'sh80000000 :
                       (i % 4 == 2) ? 32'sh0 : $urandom;
      it.coord_y     = (i % 3 == 0) ? 32'sh80000000 : (i % 3 == 1) ? 32'sh7fffffff :
                       32'sh00010000;
      it.coord_z     = COORD_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      drive_item(it, 0);
    end
    // reset value of num_points, t at zero, one lsb, boundaries, one and above
    for (int i = 0; i < 8; i++) begin
      it = '0;
      it.action = ACT_EVAL;
      it.t_pos  = edge_t[i];
      drive_item(it, 0);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_num_points(phase_points[p]);
      case (p % 4)
        1: idle_pct = 47;
        3: idle_pct = 19;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.action      = ($urandom_range(0, 99) < 85) ? ACT_EVAL : ACT_WRITE;
        it.point_index = IDX_W'($urandom_range(0, MAX_POINTS - 1));
        it.coord_x     = pick_coord();
        it.coord_y     = pick_coord();
        it.coord_z     = pick_coord();
        it.t_pos       = pick_t(spline.active_points() - 1);
        drive_item(it, idle_pct);
      end
    end

    settle();
    if (spline.expected_pos.size() != 0) begin
      $error("%0d evaluations never returned a result", spline.expected_pos.size());
      spline.mismatches++;
    end
    $display("covered %0d evaluations and %0d point writes over %0d num_points settings",
             spline.evals, spline.writes, settings_used);
    $display("including out-of-range num_points, t at and beyond one, and saturating points");
    if (spline.mismatches == 0) begin
      $display("catmull_rom_spline_eval regression: pass");
    end else begin
      $display("catmull_rom_spline_eval regression: fail");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/crse_pkg.sv
hw/rtl/crse_point_store.sv
hw/rtl/crse_axis_lane.sv
hw/rtl/crse_merge.sv
hw/rtl/catmull_rom_spline_eval.sv
tb/sv/catmull_rom_spline_eval_tb.sv
